### src/mlt_pkg.sv
// shared types, constants and microcode of the motion level tracker
package mlt_pkg;

   localparam int STEP_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COEF_W = 17;
   localparam int WEIGHT_W = 16;
   localparam int PROD_W = 49;
   localparam int ACC_W = 51;

   localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;

   localparam logic [CSR_INDEX_W-1:0] REG_FAST_ATTACK = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FAST_DECAY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOW_ATTACK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOW_DECAY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MEAN_WEIGHT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SPREAD_WEIGHT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TRIGGER_LEVEL = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_FRAMES = 3'd7;

   // tracker slots: bit 0 picks spread, bit 1 picks slow
   localparam logic [1:0] TRK_FAST_MEAN = 2'd0;
   localparam logic [1:0] TRK_FAST_SPREAD = 2'd1;
   localparam logic [1:0] TRK_SLOW_MEAN = 2'd2;
   localparam logic [1:0] TRK_SLOW_SPREAD = 2'd3;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_MUL_TRK,
      OP_UPD_TRK,
      OP_CLAMP,
      OP_MUL_LVL,
      OP_ACC_LVL,
      OP_LEVEL,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_REQ,
      HOLD_OUT
   } hold_type;

   typedef struct packed {
      op_type              op;
      logic [1:0]          sel;
      hold_type            hold;
      logic                jump;
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_fire;
      logic out_free;
   } status_type;

   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      unique case (step)
         4'd0:  w = '{OP_WAIT,    2'd0,            HOLD_REQ,  1'b0, 4'd0};
         4'd1:  w = '{OP_MUL_TRK, TRK_FAST_MEAN,   HOLD_NONE, 1'b0, 4'd0};
         4'd2:  w = '{OP_UPD_TRK, TRK_FAST_MEAN,   HOLD_NONE, 1'b0, 4'd0};
         4'd3:  w = '{OP_MUL_TRK, TRK_FAST_SPREAD, HOLD_NONE, 1'b0, 4'd0};
         4'd4:  w = '{OP_UPD_TRK, TRK_FAST_SPREAD, HOLD_NONE, 1'b0, 4'd0};
         4'd5:  w = '{OP_MUL_TRK, TRK_SLOW_MEAN,   HOLD_NONE, 1'b0, 4'd0};
         4'd6:  w = '{OP_UPD_TRK, TRK_SLOW_MEAN,   HOLD_NONE, 1'b0, 4'd0};
         4'd7:  w = '{OP_MUL_TRK, TRK_SLOW_SPREAD, HOLD_NONE, 1'b0, 4'd0};
         4'd8:  w = '{OP_UPD_TRK, TRK_SLOW_SPREAD, HOLD_NONE, 1'b0, 4'd0};
         4'd9:  w = '{OP_CLAMP,   2'd0,            HOLD_NONE, 1'b0, 4'd0};
         4'd10: w = '{OP_MUL_LVL, 2'd0,            HOLD_NONE, 1'b0, 4'd0};
         4'd11: w = '{OP_ACC_LVL, 2'd0,            HOLD_NONE, 1'b0, 4'd0};
         4'd12: w = '{OP_MUL_LVL, 2'd1,            HOLD_NONE, 1'b0, 4'd0};
         4'd13: w = '{OP_ACC_LVL, 2'd1,            HOLD_NONE, 1'b0, 4'd0};
         4'd14: w = '{OP_LEVEL,   2'd0,            HOLD_NONE, 1'b0, 4'd0};
         4'd15: w = '{OP_EMIT,    2'd0,            HOLD_OUT,  1'b1, 4'd0};
      endcase
      return w;
   endfunction

endpackage

### src/mlt_if.sv
// request and response channel interfaces
interface mlt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] frame_mean;
   logic [31:0] frame_spread;

   modport source (output valid, output frame_mean, output frame_spread, input ready);
   modport sink (input valid, input frame_mean, input frame_spread, output ready);
endinterface

interface mlt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] level;
   logic               detected;
   logic               save_frame;
   logic               run_start;
   logic               run_end;
   logic [15:0]        run_length;
   logic [31:0]        fast_mean_out;
   logic [31:0]        slow_mean_out;

   modport source (output valid, output level, output detected, output save_frame,
                   output run_start, output run_end, output run_length,
                   output fast_mean_out, output slow_mean_out, input ready);
   modport sink (input valid, input level, input detected, input save_frame,
                 input run_start, input run_end, input run_length,
                 input fast_mean_out, input slow_mean_out, output ready);
endinterface

### src/mlt_sequencer.sv
// microcode step counter and control store
module mlt_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  mlt_pkg::status_type      status,
   output mlt_pkg::ctrl_word_type   ctl
);

   logic [mlt_pkg::STEP_W-1:0] step_ff;
   logic [mlt_pkg::STEP_W-1:0] step_in;
   logic                       stall;

   assign ctl = mlt_pkg::ucode(step_ff);

   always_comb begin
      unique case (ctl.hold)
         mlt_pkg::HOLD_REQ: stall = !status.req_fire;
         mlt_pkg::HOLD_OUT: stall = !status.out_free;
         default:           stall = 1'b0;
      endcase
      priority if (stall) begin
         step_in = step_ff;
      end else if (ctl.jump) begin
         step_in = ctl.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### src/mlt_datapath.sv
// trackers, shared multiplier, level accumulator, flags and output register
module mlt_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [mlt_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [mlt_pkg::CSR_DATA_W-1:0]         csr_data,
   input  mlt_pkg::ctrl_word_type                 ctl,
   output mlt_pkg::status_type                    status,
   mlt_req_if.sink                                req_ch,
   mlt_rsp_if.source                              rsp_ch
);

   // configuration
   logic [mlt_pkg::COEF_W-1:0]   fast_attack_ff, fast_decay_ff;
   logic [mlt_pkg::COEF_W-1:0]   slow_attack_ff, slow_decay_ff;
   logic [mlt_pkg::WEIGHT_W-1:0] mean_weight_ff, spread_weight_ff;
   logic signed [31:0]           trigger_ff;
   logic [7:0]                   hold_frames_ff;

   // working state
   logic [31:0]                  trk_ff [4];
   logic [31:0]                  trk_in [4];
   logic [31:0]                  mean_ff, spread_ff;
   logic                         rising_ff;
   logic [mlt_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [mlt_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0]           level_ff, level_in;
   logic [7:0]                   hold_ff, hold_in;
   logic [15:0]                  run_ff, run_in;

   // output register
   logic                         rsp_valid_ff;
   logic signed [31:0]           out_level_ff;
   logic                         out_det_ff, out_save_ff, out_start_ff, out_end_ff;
   logic [15:0]                  out_len_ff, len_in;
   logic [31:0]                  out_fast_ff, out_slow_ff;

   logic                         req_fire, out_free, emit, det, rising;
   logic [31:0]                  x_cur, in_cur, mag, mul_a, q;
   logic [mlt_pkg::COEF_W-1:0]   coef_raw, coef, mul_b;
   logic [mlt_pkg::PROD_W:0]     rnd;
   logic signed [mlt_pkg::ACC_W-9:0] shifted;

   assign req_ch.ready = (ctl.op == mlt_pkg::OP_WAIT);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit = (ctl.op == mlt_pkg::OP_EMIT) && out_free;
   assign status = '{req_fire: req_fire, out_free: out_free};

   // tracker step operands
   always_comb begin
      x_cur = trk_ff[ctl.sel];
      in_cur = ctl.sel[0] ? spread_ff : mean_ff;
      rising = in_cur >= x_cur;
      mag = rising ? in_cur - x_cur : x_cur - in_cur;
      unique case ({ctl.sel[1], rising})
         2'b01:   coef_raw = fast_attack_ff;
         2'b00:   coef_raw = fast_decay_ff;
         2'b11:   coef_raw = slow_attack_ff;
         default: coef_raw = slow_decay_ff;
      endcase
      coef = (coef_raw > mlt_pkg::COEF_ONE) ? mlt_pkg::COEF_ONE : coef_raw;
   end

   // shared multiplier
   always_comb begin
      if (ctl.op == mlt_pkg::OP_MUL_TRK) begin
         mul_a = mag;
         mul_b = coef;
      end else begin
         mul_a = ctl.sel[0] ? trk_ff[mlt_pkg::TRK_SLOW_SPREAD] : trk_ff[mlt_pkg::TRK_SLOW_MEAN];
         mul_b = {1'b0, (ctl.sel[0] ? spread_weight_ff : mean_weight_ff)};
      end
      prod_in = mlt_pkg::PROD_W'(mul_a) * mlt_pkg::PROD_W'(mul_b);
   end

   // round half up: toward the new input when rising, away from it when falling
   always_comb begin
      rnd = {1'b0, prod_ff} + (rising_ff ? 50'd32768 : 50'd32767);
      q = rnd[47:16];
   end

   always_comb begin
      shifted = acc_ff[mlt_pkg::ACC_W-1:8];
      if (shifted[42:31] == {12{shifted[42]}}) begin
         level_in = shifted[31:0];
      end else if (shifted[42]) begin
         level_in = 32'sh8000_0000;
      end else begin
         level_in = 32'sh7FFF_FFFF;
      end
   end

   always_comb begin
      trk_in = trk_ff;
      acc_in = acc_ff;
      unique case (ctl.op)
         mlt_pkg::OP_UPD_TRK: begin
            trk_in[ctl.sel] = rising_ff ? x_cur + q : x_cur - q;
         end
         mlt_pkg::OP_CLAMP: begin
            if (trk_ff[mlt_pkg::TRK_SLOW_MEAN] > trk_ff[mlt_pkg::TRK_FAST_MEAN]) begin
               trk_in[mlt_pkg::TRK_SLOW_MEAN] = trk_ff[mlt_pkg::TRK_FAST_MEAN];
            end
            if (trk_ff[mlt_pkg::TRK_SLOW_SPREAD] > trk_ff[mlt_pkg::TRK_FAST_SPREAD]) begin
               trk_in[mlt_pkg::TRK_SLOW_SPREAD] = trk_ff[mlt_pkg::TRK_FAST_SPREAD];
            end
         end
         mlt_pkg::OP_ACC_LVL: begin
            if (ctl.sel[0]) begin
               acc_in = acc_ff - $signed({2'b00, prod_ff});
            end else begin
               acc_in = $signed({11'd0, trk_ff[mlt_pkg::TRK_FAST_MEAN], 8'd0})
                      - $signed({2'b00, prod_ff});
            end
         end
         default: begin
         end
      endcase
   end

   // detection flags and counters
   always_comb begin
      det = level_ff >= trigger_ff;
      if (det) begin
         hold_in = hold_frames_ff;
         run_in = (run_ff != 16'hFFFF) ? run_ff + 1'b1 : run_ff;
         len_in = run_in;
      end else begin
         hold_in = (hold_ff != 8'd0) ? hold_ff - 1'b1 : hold_ff;
         run_in = 16'd0;
         len_in = run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_attack_ff <= 17'd6554;
         fast_decay_ff <= 17'd9830;
         slow_attack_ff <= 17'd655;
         slow_decay_ff <= 17'd983;
         mean_weight_ff <= 16'd256;
         spread_weight_ff <= 16'd512;
         trigger_ff <= 32'sd196608000;
         hold_frames_ff <= 8'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            mlt_pkg::REG_FAST_ATTACK:   fast_attack_ff <= csr_data[16:0];
            mlt_pkg::REG_FAST_DECAY:    fast_decay_ff <= csr_data[16:0];
            mlt_pkg::REG_SLOW_ATTACK:   slow_attack_ff <= csr_data[16:0];
            mlt_pkg::REG_SLOW_DECAY:    slow_decay_ff <= csr_data[16:0];
            mlt_pkg::REG_MEAN_WEIGHT:   mean_weight_ff <= csr_data[15:0];
            mlt_pkg::REG_SPREAD_WEIGHT: spread_weight_ff <= csr_data[15:0];
            mlt_pkg::REG_TRIGGER_LEVEL: trigger_ff <= $signed(csr_data[31:0]);
            mlt_pkg::REG_HOLD_FRAMES:   hold_frames_ff <= csr_data[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            trk_ff[i] <= '0;
         end
         hold_ff <= '0;
         run_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         trk_ff <= trk_in;
         if (emit) begin
            hold_ff <= hold_in;
            run_ff <= run_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mean_ff <= req_ch.frame_mean;
         spread_ff <= req_ch.frame_spread;
      end
      if (ctl.op == mlt_pkg::OP_MUL_TRK) begin
         rising_ff <= rising;
      end
      if (ctl.op == mlt_pkg::OP_MUL_TRK || ctl.op == mlt_pkg::OP_MUL_LVL) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (ctl.op == mlt_pkg::OP_LEVEL) begin
         level_ff <= level_in;
      end
      if (emit) begin
         out_level_ff <= level_ff;
         out_det_ff <= det;
         out_save_ff <= det || (hold_ff != 8'd0);
         out_start_ff <= det && (run_ff == 16'd0);
         out_end_ff <= !det && (run_ff != 16'd0);
         out_len_ff <= len_in;
         out_fast_ff <= trk_ff[mlt_pkg::TRK_FAST_MEAN];
         out_slow_ff <= trk_ff[mlt_pkg::TRK_SLOW_MEAN];
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.level = out_level_ff;
   assign rsp_ch.detected = out_det_ff;
   assign rsp_ch.save_frame = out_save_ff;
   assign rsp_ch.run_start = out_start_ff;
   assign rsp_ch.run_end = out_end_ff;
   assign rsp_ch.run_length = out_len_ff;
   assign rsp_ch.fast_mean_out = out_fast_ff;
   assign rsp_ch.slow_mean_out = out_slow_ff;

`ifndef SYNTH
   a_clamp_holds: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == mlt_pkg::OP_EMIT) |->
         (trk_ff[mlt_pkg::TRK_SLOW_MEAN] <= trk_ff[mlt_pkg::TRK_FAST_MEAN]) &&
         (trk_ff[mlt_pkg::TRK_SLOW_SPREAD] <= trk_ff[mlt_pkg::TRK_FAST_SPREAD]))
      else $error("slow tracker above fast tracker at emit");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted result not presented");

   a_start_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_start_ff) |-> (out_len_ff == 16'd1) && out_det_ff)
      else $error("run start without unit run length");

   a_save_det: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_det_ff) |-> out_save_ff && !out_end_ff)
      else $error("detected frame not saved or flagged as run end");
`endif

endmodule

### src/motion_level_tracker.sv
// top level of the motion level tracker
// One request per frame carries the frame's difference mean and deviation. A fast and a slow
// tracker follow each statistic; the slow ones are clamped to the fast ones and a detection
// level is formed and compared with the threshold, giving detect, save, run start, run end
// and run length flags. A microcoded sequencer steps a single shared 32 by 17 multiplier
// through the work: two steps per tracker, one clamp step, four steps for the level and one
// to saturate, then the result goes to the output register. A new request is taken only
// after the result is registered, so each request is finished before the next is taken;
// the emit step waits while the response side is full. Register writes are taken at any
// time and are meant to be made while the block is idle.
module motion_level_tracker (
   input  logic                                clock,
   input  logic                                reset,
   mlt_req_if.sink                             req_ch,
   mlt_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [mlt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mlt_pkg::CSR_DATA_W-1:0]      csr_data
);

   mlt_pkg::ctrl_word_type ctl;
   mlt_pkg::status_type    status;

   mlt_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   mlt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .status    (status),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

endmodule
